// ===== hdl/ipv6fk_pkg.sv =====
package ipv6fk_pkg;

    typedef enum logic [2:0] {
        PH_FIXED  = 3'd0,
        PH_SEEK   = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_UPPER  = 3'd3,
        PH_LOST   = 3'd4
    } phase_t;

    localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] NH_ROUTING    = 8'd43;
    localparam logic [7:0] NH_DEST_OPT   = 8'd60;
    localparam logic [7:0] NH_TCP        = 8'd6;
    localparam logic [7:0] NH_UDP        = 8'd17;
    localparam logic [7:0] NH_SCTP       = 8'd132;
    localparam logic [7:0] NH_ICMPV6     = 8'd58;
    localparam logic [7:0] NH_MOBILITY   = 8'd135;

    localparam logic [2:0] PORT_BYTES     = 3'd4;
    localparam logic [2:0] ICMP_BYTES     = 3'd2;
    localparam logic [2:0] MOBILITY_BYTES = 3'd3;
    localparam logic [2:0] FIRST_BYTE     = 3'd1;

    typedef struct packed {
        logic [7:0]  packet_byte;
        logic        last_byte;
        logic [15:0] interface_index;
    } pkt_t;

    typedef struct packed {
        logic [63:0] dest_addr_high;
        logic [63:0] dest_addr_low;
        logic [63:0] source_addr_high;
        logic [63:0] source_addr_low;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [7:0]  mobility_type;
        logic [15:0] out_interface;
        logic        found;
    } key_t;

endpackage

// ===== hdl/ipv6_flow_key_extractor.sv =====
// IPv6 flow key extractor: takes a packet one byte per request on pkt_*, starting at the
// fixed header, and returns one flow key on key_* for the request that carries the last
// byte. Addresses come from the fixed header; hop-by-hop, routing and destination-option
// headers are skipped by their length byte, and the first other header gives the protocol
// plus ports (TCP/UDP/SCTP), ICMPv6 type/code or the mobility type (when cfg enables it).
// A byte is taken every cycle while not stalled; each byte passes an input register and one
// short parse step into the state and key registers, and the key is driven from those. Input
// stalls only while a finished key is held by key_stall. The position counter has
// POSITION_BITS bits and saturates; headers past its range are not found.
module ipv6_flow_key_extractor #(
    parameter int POSITION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pkt_valid,
    output logic              pkt_stall,
    input  ipv6fk_pkg::pkt_t  pkt_data,
    output logic              key_valid,
    input  logic              key_stall,
    output ipv6fk_pkg::key_t  key_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int P     = POSITION_BITS;
    localparam int SUM_W = ((P > 12) ? P : 12) + 1;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};

    logic                 advance;
    logic                 mobility_enable_reg;

    logic                 s1_valid_reg;
    ipv6fk_pkg::pkt_t     s1_data_reg;

    logic [P-1:0]         byte_position_reg, byte_position_next;
    logic [P-1:0]         header_start_reg, header_start_next;
    logic [7:0]           next_header_reg, next_header_next;
    ipv6fk_pkg::phase_t   phase_reg, phase_next;
    logic [3:0][63:0]     addr_reg, addr_next;
    logic [3:0][7:0]      upper_reg, upper_next;
    logic [2:0]           seen_reg, seen_next;
    logic [7:0]           stopped_reg, stopped_next;

    logic                 key_valid_reg, key_valid_next;
    ipv6fk_pkg::key_t     key_data_reg, key_data_next;

    logic [P-1:0]         pos_off;
    logic [SUM_W-1:0]     ext_next;
    logic [7:0]           b;
    logic                 is_ext;

    assign advance   = !(key_valid_reg && key_stall);
    assign pkt_stall = !advance;
    assign cfg_ready = 1'b1;
    assign key_valid = key_valid_reg;
    assign key_data  = key_data_reg;

    assign b       = s1_data_reg.packet_byte;
    assign pos_off = byte_position_reg - P'(8);
    assign is_ext  = (next_header_reg == ipv6fk_pkg::NH_HOP_BY_HOP)
                  || (next_header_reg == ipv6fk_pkg::NH_ROUTING)
                  || (next_header_reg == ipv6fk_pkg::NH_DEST_OPT);
    assign ext_next = SUM_W'(header_start_reg)
                    + ((SUM_W'(b) + SUM_W'(1)) << 3);

    always_comb
    begin
        byte_position_next = byte_position_reg;
        header_start_next  = header_start_reg;
        next_header_next   = next_header_reg;
        phase_next         = phase_reg;
        addr_next          = addr_reg;
        upper_next         = upper_reg;
        seen_next          = seen_reg;
        stopped_next       = stopped_reg;
        key_valid_next     = 1'b0;
        key_data_next      = key_data_reg;

        if (s1_valid_reg)
        begin
            case (phase_reg)
                ipv6fk_pkg::PH_FIXED:
                begin
                    if (byte_position_reg == P'(6))
                        next_header_next = b;
                    if (byte_position_reg >= P'(8) && byte_position_reg < P'(40))
                        addr_next[pos_off[4:3]] = {addr_reg[pos_off[4:3]][55:0], b};
                    if (byte_position_reg == P'(39))
                        phase_next = ipv6fk_pkg::PH_SEEK;
                end
                ipv6fk_pkg::PH_SEEK:
                begin
                    if (byte_position_reg == header_start_reg)
                    begin
                        if (is_ext)
                        begin
                            next_header_next = b;
                            phase_next       = ipv6fk_pkg::PH_EXTLEN;
                        end
                        else
                        begin
                            stopped_next  = next_header_reg;
                            upper_next[0] = b;
                            seen_next     = ipv6fk_pkg::FIRST_BYTE;
                            phase_next    = ipv6fk_pkg::PH_UPPER;
                        end
                    end
                end
                ipv6fk_pkg::PH_EXTLEN:
                begin
                    // header start beyond the counter range can never be reached
                    if (ext_next > SUM_W'(POS_MAX))
                        phase_next = ipv6fk_pkg::PH_LOST;
                    else
                    begin
                        header_start_next = ext_next[P-1:0];
                        phase_next        = ipv6fk_pkg::PH_SEEK;
                    end
                end
                ipv6fk_pkg::PH_UPPER:
                begin
                    if (seen_reg < ipv6fk_pkg::PORT_BYTES)
                    begin
                        upper_next[seen_reg[1:0]] = b;
                        seen_next = seen_reg + 3'd1;
                    end
                end
                default:
                begin
                end
            endcase

            if (byte_position_reg < POS_MAX)
                byte_position_next = byte_position_reg + P'(1);
            else if (phase_next != ipv6fk_pkg::PH_UPPER)
                phase_next = ipv6fk_pkg::PH_LOST;

            if (s1_data_reg.last_byte)
            begin
                key_valid_next                 = 1'b1;
                key_data_next.dest_addr_high   = addr_next[2];
                key_data_next.dest_addr_low    = addr_next[3];
                key_data_next.source_addr_high = addr_next[0];
                key_data_next.source_addr_low  = addr_next[1];
                key_data_next.protocol         = 8'd0;
                key_data_next.source_port      = 16'd0;
                key_data_next.dest_port        = 16'd0;
                key_data_next.icmp_type        = 8'd0;
                key_data_next.icmp_code        = 8'd0;
                key_data_next.mobility_type    = 8'd0;
                key_data_next.out_interface    = 16'd0;
                key_data_next.found            = 1'b0;
                if (phase_next == ipv6fk_pkg::PH_UPPER)
                begin
                    key_data_next.protocol      = stopped_next;
                    key_data_next.out_interface = s1_data_reg.interface_index;
                    key_data_next.found         = 1'b1;
                    if (stopped_next == ipv6fk_pkg::NH_TCP
                        || stopped_next == ipv6fk_pkg::NH_UDP
                        || stopped_next == ipv6fk_pkg::NH_SCTP)
                    begin
                        if (seen_next >= ipv6fk_pkg::PORT_BYTES)
                        begin
                            key_data_next.source_port = {upper_next[0], upper_next[1]};
                            key_data_next.dest_port   = {upper_next[2], upper_next[3]};
                        end
                    end
                    else if (stopped_next == ipv6fk_pkg::NH_ICMPV6)
                    begin
                        if (seen_next >= ipv6fk_pkg::ICMP_BYTES)
                        begin
                            key_data_next.icmp_type = upper_next[0];
                            key_data_next.icmp_code = upper_next[1];
                        end
                    end
                    else if (stopped_next == ipv6fk_pkg::NH_MOBILITY && mobility_enable_reg)
                    begin
                        if (seen_next >= ipv6fk_pkg::MOBILITY_BYTES)
                            key_data_next.mobility_type = upper_next[2];
                    end
                end

                // back to the start of a packet
                byte_position_next = '0;
                header_start_next  = P'(40);
                next_header_next   = 8'd0;
                phase_next         = ipv6fk_pkg::PH_FIXED;
                addr_next          = '0;
                upper_next         = '0;
                seen_next          = 3'd0;
                stopped_next       = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mobility_enable_reg <= 1'b1;
            s1_valid_reg        <= 1'b0;
            key_valid_reg       <= 1'b0;
            byte_position_reg   <= '0;
            header_start_reg    <= P'(40);
            next_header_reg     <= 8'd0;
            phase_reg           <= ipv6fk_pkg::PH_FIXED;
            addr_reg            <= '0;
            upper_reg           <= '0;
            seen_reg            <= 3'd0;
            stopped_reg         <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mobility_enable_reg <= cfg_data;
            if (advance)
            begin
                s1_valid_reg      <= pkt_valid;
                key_valid_reg     <= key_valid_next;
                byte_position_reg <= byte_position_next;
                header_start_reg  <= header_start_next;
                next_header_reg   <= next_header_next;
                phase_reg         <= phase_next;
                addr_reg          <= addr_next;
                upper_reg         <= upper_next;
                seen_reg          <= seen_next;
                stopped_reg       <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_data_reg  <= pkt_data;
            key_data_reg <= key_data_next;
        end
    end

    a_pos_past_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != ipv6fk_pkg::PH_FIXED |-> byte_position_reg >= P'(40))
        else $error("parse left fixed header before byte 40");

    a_header_start_min: assert property (@(posedge clk) disable iff (!rst_n)
        header_start_reg >= P'(40))
        else $error("header start below end of fixed header");

    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= ipv6fk_pkg::PORT_BYTES)
        else $error("upper byte count out of range");

    a_upper_seen: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ipv6fk_pkg::PH_UPPER |-> seen_reg >= ipv6fk_pkg::FIRST_BYTE)
        else $error("upper phase without a captured byte");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid_reg && !key_data_reg.found
        |-> key_data_reg.protocol == 8'd0 && key_data_reg.out_interface == 16'd0)
        else $error("key without stopping header reports protocol or interface");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid_reg && key_stall |=> $stable(byte_position_reg) && $stable(phase_reg))
        else $error("parse state moved while key held");

endmodule
